>>> rtl/bce_pkg.sv
// shared types, constants and approximation tables for the bce with logits loss/grad core
// no dependencies; tables are built at elaboration by constant functions
package bce_pkg;

    localparam int FracBits   = 16;
    localparam int TabEntries = 256;
    localparam int TabW       = 18;
    localparam int TabIdxW    = $clog2(TabEntries + 1);
    localparam int LogitW     = 32;
    localparam int TargetW    = 17;
    localparam int GradW      = 32;
    localparam int CountW     = 24;
    localparam int SumW       = 58;
    localparam int MeanW      = 34;
    localparam int TermW      = 33;
    localparam int MagW       = 32;
    localparam int PosW       = LogitW + TabIdxW;
    localparam int RemW       = FracBits + 4;
    localparam int IdxW       = PosW - RemW;
    localparam int ProdW      = TabW + RemW + 2;
    localparam int PyW        = LogitW + TargetW + 1;
    localparam int NumW       = GradW + TabW + 2;
    localparam int DigitsPerCycle = 4;
    localparam int DivCycles  = (SumW + DigitsPerCycle - 1) / DigitsPerCycle;
    localparam int DivPad     = DivCycles * DigitsPerCycle;
    localparam int DivCntW    = $clog2(DivCycles + 1);
    localparam logic [TargetW-1:0] OneFx = TargetW'(1 << FracBits);
    localparam logic [SumW-1:0]  SumMax  = {SumW{1'b1}};
    localparam logic [MeanW-1:0] MeanMax = {MeanW{1'b1}};

    typedef enum logic [0:0] {
        CfgElementCount = 1'b0,
        CfgUpstreamGrad = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_LOOK,
        F_SUM,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_GRAD,
        B_MEAN,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic [MagW-1:0]         num_mag;
        logic                    num_neg;
        logic signed [GradW-1:0] grad_in;
        logic [TermW-1:0]        term;
        logic                    last;
    } job_t;

    // all samples packed, sample k in bits [k*TabW +: TabW]
    typedef logic [(TabEntries + 1)*TabW-1:0] tab_t;

    // shift-subtract quotient, only evaluated while building the tables
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-f) for f in [0,1), Q2.30
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        longint      s;
        logic [63:0] term;
        s    = longint'(64'd1 << 30);
        term = 64'd1 << 30;
        for (int n = 1; n <= 20; n++)
        begin
            term = udiv64((term * f) >> 30, 64'(n));
            if ((n & 1) == 1)
                s = s - longint'(term);
            else
                s = s + longint'(term);
        end
        return (s < 0) ? 64'd0 : 64'(s);
    endfunction

    // log(1+t) for t in [0,1], Q2.30, via 2*atanh(t/(2+t))
    function automatic logic [63:0] log1p_q30(input logic [63:0] t);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] pw;
        logic [63:0] s;
        u  = udiv64(t << 30, (64'd2 << 30) + t);
        u2 = (u * u) >> 30;
        pw = u;
        s  = 64'd0;
        for (int k = 0; k < 20; k++)
        begin
            s  = s + udiv64(pw, 64'(2 * k + 1));
            pw = (pw * u2) >> 30;
        end
        return s << 1;
    endfunction

    function automatic logic signed [TabW-1:0] to_fx(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
        return TabW'(r);
    endfunction

    // want_sig selects sigmoid, otherwise softplus of -x
    function automatic tab_t build_tab(input logic want_sig);
        tab_t        t;
        logic [63:0] x;
        logic [63:0] q;
        logic [63:0] e;
        t = '0;
        for (int k = 0; k <= TabEntries; k++)
        begin
            x = udiv64((64'(k) * 64'd16) << 30, 64'(TabEntries));
            q = x >> 30;
            e = exp_neg_frac(x & ((64'd1 << 30) - 64'd1));
            for (int i = 0; i < 16; i++)
            begin
                if (64'(i) < q)
                    e = (e * 64'd395007543 + (64'd1 << 29)) >> 30;
            end
            if (want_sig)
                t[k*TabW +: TabW] = to_fx(udiv64(64'd1 << 60, (64'd1 << 30) + e));
            else
                t[k*TabW +: TabW] = to_fx(log1p_q30(e));
        end
        return t;
    endfunction

    localparam tab_t SpTab = build_tab(1'b0);
    localparam tab_t SgTab = build_tab(1'b1);

    function automatic logic signed [TabW-1:0] sp_at(input logic [TabIdxW-1:0] i);
        return $signed(SpTab[i*TabW +: TabW]);
    endfunction

    function automatic logic signed [TabW-1:0] sg_at(input logic [TabIdxW-1:0] i);
        return $signed(SgTab[i*TabW +: TabW]);
    endfunction

endpackage

>>> rtl/bce_fifo.sv
// small register queue between the front and back halves
// depends on nothing; payload is a flat vector
module bce_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  ent_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = ent_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= wdata;
    end

endmodule

>>> rtl/bce_front.sv
// front half: takes a beat, looks up softplus/sigmoid, forms loss term and grad numerator
// depends on bce_pkg
module bce_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [bce_pkg::LogitW-1:0] logit,
    input  logic [bce_pkg::TargetW-1:0]       target,
    input  logic signed [bce_pkg::GradW-1:0]  grad_in,
    input  logic                              last,
    input  logic signed [bce_pkg::GradW-1:0]  upstream_grad,
    input  logic                              full,
    output logic                              push,
    output bce_pkg::job_t                     job
);
    localparam int SgW  = bce_pkg::TabW + 1;
    localparam int SgyW = bce_pkg::TabW + 2;
    localparam int TsW  = bce_pkg::PyW + 2;

    bce_pkg::front_state_t state_reg, state_next;

    logic signed [bce_pkg::LogitW-1:0] p_reg;
    logic [bce_pkg::TargetW-1:0]       y_reg;
    logic signed [bce_pkg::GradW-1:0]  gin_reg;
    logic                              last_reg;
    logic signed [bce_pkg::TabW-1:0]   sp_base_reg, sg_base_reg;
    logic signed [bce_pkg::ProdW-1:0]  sp_prod_reg, sg_prod_reg;
    logic signed [bce_pkg::PyW-1:0]    py_reg;
    logic signed [SgyW-1:0]            sgy_reg;
    logic [bce_pkg::TermW-1:0]         term_reg;
    logic signed [bce_pkg::NumW-1:0]   num_reg;

    // lookup stage
    logic [bce_pkg::LogitW-1:0]  a;
    logic [bce_pkg::PosW-1:0]    pos;
    logic [bce_pkg::IdxW-1:0]    idx;
    logic [bce_pkg::RemW-1:0]    rem;
    logic                        in_range;
    logic [bce_pkg::TabIdxW-1:0] lo_i, hi_i;
    logic signed [bce_pkg::TabW:0] sp_diff, sg_diff;
    logic signed [bce_pkg::ProdW-1:0] sp_prod, sg_prod;
    logic signed [bce_pkg::PyW-1:0]   py;

    // sum stage
    logic signed [bce_pkg::ProdW-1:0] sp_tz, sg_tz;
    logic signed [SgW-1:0]            sp, sg_raw, sg;
    logic signed [bce_pkg::PyW-1:0]   py_tz;
    logic signed [TsW-1:0]            term_s;
    logic signed [SgyW-1:0]           sgy;

    // push stage
    logic [bce_pkg::NumW-1:0] num_mag;

    always_comb
    begin
        a        = p_reg[bce_pkg::LogitW-1] ? (~p_reg + 1'b1) : p_reg;
        pos      = bce_pkg::PosW'(a) * bce_pkg::PosW'(bce_pkg::TabEntries);
        idx      = pos[bce_pkg::PosW-1:bce_pkg::RemW];
        rem      = pos[bce_pkg::RemW-1:0];
        in_range = (idx < bce_pkg::IdxW'(bce_pkg::TabEntries));
        lo_i     = in_range ? idx[bce_pkg::TabIdxW-1:0]
                            : bce_pkg::TabIdxW'(bce_pkg::TabEntries);
        hi_i     = in_range ? lo_i + 1'b1 : lo_i;
        sp_diff  = (bce_pkg::TabW + 1)'(bce_pkg::sp_at(hi_i))
                 - (bce_pkg::TabW + 1)'(bce_pkg::sp_at(lo_i));
        sg_diff  = (bce_pkg::TabW + 1)'(bce_pkg::sg_at(hi_i))
                 - (bce_pkg::TabW + 1)'(bce_pkg::sg_at(lo_i));
        sp_prod  = bce_pkg::ProdW'(sp_diff) * $signed({1'b0, rem});
        sg_prod  = bce_pkg::ProdW'(sg_diff) * $signed({1'b0, rem});
        py       = bce_pkg::PyW'(p_reg) * $signed({1'b0, y_reg});
    end

    always_comb
    begin
        // divisions by powers of two truncate toward zero
        sp_tz  = (sp_prod_reg < 0)
               ? ((sp_prod_reg + bce_pkg::ProdW'((1 << bce_pkg::RemW) - 1)) >>> bce_pkg::RemW)
               : (sp_prod_reg >>> bce_pkg::RemW);
        sg_tz  = (sg_prod_reg < 0)
               ? ((sg_prod_reg + bce_pkg::ProdW'((1 << bce_pkg::RemW) - 1)) >>> bce_pkg::RemW)
               : (sg_prod_reg >>> bce_pkg::RemW);
        py_tz  = (py_reg < 0)
               ? ((py_reg + bce_pkg::PyW'((1 << bce_pkg::FracBits) - 1)) >>> bce_pkg::FracBits)
               : (py_reg >>> bce_pkg::FracBits);
        sp     = SgW'(sp_base_reg) + SgW'(sp_tz);
        sg_raw = SgW'(sg_base_reg) + SgW'(sg_tz);
        sg     = p_reg[bce_pkg::LogitW-1] ? ($signed({2'b00, bce_pkg::OneFx}) - sg_raw) : sg_raw;
        term_s = (p_reg[bce_pkg::LogitW-1] ? TsW'(0) : TsW'(p_reg)) - TsW'(py_tz) + TsW'(sp);
        sgy    = SgyW'(sg) - $signed({3'b000, y_reg});
        num_mag = num_reg[bce_pkg::NumW-1] ? (~num_reg + 1'b1) : num_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bce_pkg::F_IDLE: if (in_valid) state_next = bce_pkg::F_LOOK;
            bce_pkg::F_LOOK: state_next = bce_pkg::F_SUM;
            bce_pkg::F_SUM:  state_next = bce_pkg::F_MUL;
            bce_pkg::F_MUL:  state_next = bce_pkg::F_PUSH;
            bce_pkg::F_PUSH: if (!full) state_next = bce_pkg::F_IDLE;
            default:         state_next = bce_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            bce_pkg::F_IDLE: in_ready = 1'b1;
            bce_pkg::F_PUSH: push = !full;
            default:
            begin
                in_ready = 1'b0;
                push     = 1'b0;
            end
        endcase
        job.num_mag = num_mag[bce_pkg::FracBits +: bce_pkg::MagW];
        job.num_neg = num_reg[bce_pkg::NumW-1];
        job.grad_in = gin_reg;
        job.term    = term_reg;
        job.last    = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bce_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bce_pkg::F_IDLE && in_valid)
        begin
            p_reg    <= logit;
            y_reg    <= (target > bce_pkg::OneFx) ? bce_pkg::OneFx : target;
            gin_reg  <= grad_in;
            last_reg <= last;
        end
        if (state_reg == bce_pkg::F_LOOK)
        begin
            sp_base_reg <= bce_pkg::sp_at(lo_i);
            sg_base_reg <= bce_pkg::sg_at(lo_i);
            sp_prod_reg <= sp_prod;
            sg_prod_reg <= sg_prod;
            py_reg      <= py;
        end
        if (state_reg == bce_pkg::F_SUM)
        begin
            sgy_reg  <= sgy;
            term_reg <= (term_s < 0) ? '0 : term_s[bce_pkg::TermW-1:0];
        end
        if (state_reg == bce_pkg::F_MUL)
            num_reg <= bce_pkg::NumW'(upstream_grad) * bce_pkg::NumW'(sgy_reg);
    end

endmodule

>>> rtl/bce_div.sv
// shared unsigned radix-16 restoring divider, four quotient bits per cycle
// depends on bce_pkg
module bce_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bce_pkg::SumW-1:0]     dividend,
    input  logic [bce_pkg::CountW-1:0]   divisor,
    output logic                         done,
    output logic [bce_pkg::SumW-1:0]     quotient
);
    logic [bce_pkg::DivPad-1:0]  sh_reg, sh_next;
    logic [bce_pkg::CountW-1:0]  rem_reg, rem_next;
    logic [bce_pkg::CountW-1:0]  d_reg;
    logic [bce_pkg::DivCntW-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [bce_pkg::CountW:0]    t;

    always_comb
    begin
        sh_next  = sh_reg;
        rem_next = rem_reg;
        t        = '0;
        for (int j = 0; j < bce_pkg::DigitsPerCycle; j++)
        begin
            t       = {rem_next, sh_next[bce_pkg::DivPad-1]};
            sh_next = {sh_next[bce_pkg::DivPad-2:0], 1'b0};
            if (t >= {1'b0, d_reg})
            begin
                t          = t - {1'b0, d_reg};
                sh_next[0] = 1'b1;
            end
            rem_next = t[bce_pkg::CountW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg[bce_pkg::SumW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= bce_pkg::DivCntW'(bce_pkg::DivCycles);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == bce_pkg::DivCntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= bce_pkg::DivPad'(dividend);
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

endmodule

>>> rtl/bce_back.sv
// back half: loss sum, gradient and mean divisions, saturation and result register
// depends on bce_pkg and bce_div
module bce_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bce_pkg::job_t                     job,
    input  logic                              empty,
    output logic                              pop,
    input  logic [bce_pkg::CountW-1:0]        element_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [bce_pkg::GradW-1:0]  grad_out,
    output logic                              grad_saturated,
    output logic [bce_pkg::MeanW-1:0]         mean_loss,
    output logic                              loss_valid
);
    localparam int CW = bce_pkg::MagW + 2;
    localparam int GW = bce_pkg::MagW + 3;

    bce_pkg::back_state_t state_reg, state_next;

    bce_pkg::job_t               job_reg;
    logic [bce_pkg::SumW-1:0]    sum_reg;
    logic signed [bce_pkg::GradW-1:0] g_reg;
    logic                        gsat_reg;
    logic [bce_pkg::MeanW-1:0]   mean_reg;
    logic                        out_valid_reg;
    logic signed [bce_pkg::GradW-1:0] grad_out_reg;
    logic                        grad_sat_out_reg;
    logic [bce_pkg::MeanW-1:0]   mean_out_reg;
    logic                        loss_valid_reg;

    logic                        div_start;
    logic [bce_pkg::SumW-1:0]    div_dvd;
    logic                        div_done;
    logic [bce_pkg::SumW-1:0]    div_q;
    logic [bce_pkg::CountW-1:0]  n_safe;
    logic [bce_pkg::SumW:0]      sum_add;
    logic signed [CW-1:0]        contrib;
    logic signed [GW-1:0]        g_wide;
    logic                        out_load;

    assign n_safe = (element_count == '0) ? bce_pkg::CountW'(1) : element_count;

    bce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (n_safe),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        sum_add = {1'b0, sum_reg} + (bce_pkg::SumW + 1)'(job.term);
        contrib = job_reg.num_neg ? -$signed({2'b00, div_q[bce_pkg::MagW-1:0]})
                                  : $signed({2'b00, div_q[bce_pkg::MagW-1:0]});
        g_wide  = GW'(job_reg.grad_in) + GW'(contrib);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bce_pkg::B_IDLE: if (!empty) state_next = bce_pkg::B_GRAD;
            bce_pkg::B_GRAD:
                if (div_done)
                    state_next = job_reg.last ? bce_pkg::B_MEAN : bce_pkg::B_OUT;
            bce_pkg::B_MEAN: if (div_done) state_next = bce_pkg::B_OUT;
            bce_pkg::B_OUT:  if (!out_valid_reg || out_ready) state_next = bce_pkg::B_IDLE;
            default:         state_next = bce_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        div_start = 1'b0;
        div_dvd   = bce_pkg::SumW'(job.num_mag);
        out_load  = 1'b0;
        case (state_reg)
            bce_pkg::B_IDLE:
            begin
                pop       = !empty;
                div_start = !empty;
            end
            bce_pkg::B_GRAD:
            begin
                div_start = div_done && job_reg.last;
                div_dvd   = sum_reg;
            end
            bce_pkg::B_OUT:  out_load = !out_valid_reg || out_ready;
            default:
            begin
                pop       = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bce_pkg::B_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                sum_reg <= (sum_add > (bce_pkg::SumW + 1)'(bce_pkg::SumMax))
                         ? bce_pkg::SumMax : sum_add[bce_pkg::SumW-1:0];
            else if (out_load && job_reg.last)
                sum_reg <= '0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= job;
        if (state_reg == bce_pkg::B_GRAD && div_done)
        begin
            mean_reg <= '0;
            if (g_wide > GW'(32'sh7fffffff))
            begin
                g_reg    <= 32'sh7fffffff;
                gsat_reg <= 1'b1;
            end
            else if (g_wide < $signed(GW'(32'sh80000000)))
            begin
                g_reg    <= 32'sh80000000;
                gsat_reg <= 1'b1;
            end
            else
            begin
                g_reg    <= g_wide[bce_pkg::GradW-1:0];
                gsat_reg <= 1'b0;
            end
        end
        if (state_reg == bce_pkg::B_MEAN && div_done)
            mean_reg <= (|div_q[bce_pkg::SumW-1:bce_pkg::MeanW])
                      ? bce_pkg::MeanMax : div_q[bce_pkg::MeanW-1:0];
        if (out_load)
        begin
            grad_out_reg     <= g_reg;
            grad_sat_out_reg <= gsat_reg;
            mean_out_reg     <= mean_reg;
            loss_valid_reg   <= job_reg.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign grad_out       = grad_out_reg;
    assign grad_saturated = grad_sat_out_reg;
    assign mean_loss      = mean_out_reg;
    assign loss_valid     = loss_valid_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == bce_pkg::B_GRAD || state_reg == bce_pkg::B_MEAN))
        else $error("divider finished outside a wait state");

    a_pop_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> div_start)
        else $error("job taken without starting the gradient division");

    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !loss_valid_reg) |-> (mean_out_reg == '0))
        else $error("mean shown on a non-final beat");

endmodule

>>> rtl/bce_with_logits_loss_grad_core.sv
// bce with logits loss and gradient core. a beat passes the front and then the back; a last beat
// runs a second division in the back. the back finishes one beat before it takes the next; the shared
// 4-bit-per-cycle divider serves both divisions. the front runs concurrently through a small queue,
// so the back sets the rate. rst_n clears control, loss sum, element_count to 1, upstream_grad 1.0
module bce_with_logits_loss_grad_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // logit[31:0], target[48:32], grad_in[80:49], zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // grad_out[31:0], grad_saturated[32], mean_loss[66:33]
    output logic        m_axis_tuser,   // loss_valid
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);
    localparam int JobW = $bits(bce_pkg::job_t);

    logic [bce_pkg::CountW-1:0]       element_count_reg;
    logic signed [bce_pkg::GradW-1:0] upstream_grad_reg;

    logic                             push, pop, full, empty;
    bce_pkg::job_t                    job_in, job_out;
    logic [JobW-1:0]                  q_rdata;

    logic signed [bce_pkg::GradW-1:0] grad_out;
    logic                             grad_saturated;
    logic [bce_pkg::MeanW-1:0]        mean_loss;
    logic                             loss_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= bce_pkg::CountW'(1);
            upstream_grad_reg <= 32'sd65536;
        end
        else if (cfg_we)
        begin
            case (bce_pkg::cfg_idx_t'(cfg_addr))
                bce_pkg::CfgElementCount: element_count_reg <= cfg_wdata[bce_pkg::CountW-1:0];
                bce_pkg::CfgUpstreamGrad: upstream_grad_reg <= cfg_wdata;
                default:                  element_count_reg <= element_count_reg;
            endcase
        end
    end

    bce_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .logit         (s_axis_tdata[31:0]),
        .target        (s_axis_tdata[48:32]),
        .grad_in       (s_axis_tdata[80:49]),
        .last          (s_axis_tlast),
        .upstream_grad (upstream_grad_reg),
        .full          (full),
        .push          (push),
        .job           (job_in)
    );

    bce_fifo #(
        .W     (JobW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .pop   (pop),
        .rdata (q_rdata),
        .full  (full),
        .empty (empty)
    );

    assign job_out = bce_pkg::job_t'(q_rdata);

    bce_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job            (job_out),
        .empty          (empty),
        .pop            (pop),
        .element_count  (element_count_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .grad_out       (grad_out),
        .grad_saturated (grad_saturated),
        .mean_loss      (mean_loss),
        .loss_valid     (loss_valid)
    );

    assign m_axis_tdata = {5'b0, mean_loss, grad_saturated, grad_out};
    assign m_axis_tuser = loss_valid;

endmodule

>>> verif/tb_bce_with_logits_loss_grad_core.sv
// self-checking testbench for bce_with_logits_loss_grad_core: stream driver and monitor
// with random gaps, a local loss/gradient predictor and directed plus random elements
// depends on rtl/bce_pkg.sv (cfg_idx_t) and the core itself
module tb_bce_with_logits_loss_grad_core;

    localparam int Ents = 256;
    localparam longint OneQ = 64'sd65536;
    localparam logic [63:0] LossSumCap = (64'd1 << 58) - 64'd1;
    localparam logic [63:0] MeanCap = (64'd1 << 34) - 64'd1;

    typedef struct {
        logic signed [31:0] logit;
        logic [16:0]        target;
        logic signed [31:0] grad_in;
        logic               last;
    } element_t;

    typedef struct {
        logic [31:0] grad_out;
        logic        grad_sat;
        logic [33:0] mean_loss;
        logic        loss_valid;
    } grad_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    bce_pkg::cfg_idx_t cfg_addr;
    logic [31:0] cfg_wdata;

    bce_with_logits_loss_grad_core u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    longint softplus_lut [Ents + 1];
    longint sigmoid_lut [Ents + 1];
    logic [23:0]  elem_count;
    logic [31:0]  upstream;
    logic [63:0]  loss_acc;
    element_t     pending_elems [$];
    grad_result_t expected_grads [$];
    bit           in_taken;
    bit           src_steady;
    bit           sink_steady;
    int           src_gap;
    int           sink_gap;
    int           errors;

    // exp(-f), f in [0,1), Q2.30 by taylor series
    function automatic logic [63:0] exp_frac_q30(input logic [63:0] f);
        longint      acc;
        logic [63:0] t;
        acc = 64'sd1 << 30;
        t = 64'd1 << 30;
        for (int i = 1; i <= 20; i++)
        begin
            t = ((t * f) >> 30) / 64'(i);
            acc = (i % 2) ? acc - longint'(t) : acc + longint'(t);
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    function automatic logic [63:0] ln1p_q30(input logic [63:0] t);
        logic [63:0] u, u2, pw, acc;
        u = (t << 30) / ((64'd2 << 30) + t);
        u2 = (u * u) >> 30;
        pw = u;
        acc = 0;
        for (int i = 0; i < 20; i++)
        begin
            acc = acc + pw / 64'(2 * i + 1);
            pw = (pw * u2) >> 30;
        end
        return acc << 1;
    endfunction

    function automatic longint q30_to_q16(input logic [63:0] v);
        return longint'((v + (64'd1 << 13)) >> 14);
    endfunction

    function automatic void fill_luts();
        logic [63:0] x, e;
        for (int k = 0; k <= Ents; k++)
        begin
            x = ((64'(k) * 64'd16) << 30) / Ents;
            e = exp_frac_q30(x & ((64'd1 << 30) - 1));
            for (int i = 0; i < int'(x >> 30); i++)
                e = (e * 64'd395007543 + (64'd1 << 29)) >> 30;
            softplus_lut[k] = q30_to_q16(ln1p_q30(e));
            sigmoid_lut[k] = q30_to_q16((64'd1 << 60) / ((64'd1 << 30) + e));
        end
    endfunction

    function automatic longint lut_read(input bit sig, input longint idx, input longint rem);
        longint lo, hi;
        if (idx >= Ents)
            return sig ? sigmoid_lut[Ents] : softplus_lut[Ents];
        lo = sig ? sigmoid_lut[idx] : softplus_lut[idx];
        hi = sig ? sigmoid_lut[idx + 1] : softplus_lut[idx + 1];
        return lo + ((hi - lo) * rem) / (longint'(16) << 16);
    endfunction

    // loss accumulation and gradient of one element
    function automatic grad_result_t bce_element(input element_t el);
        grad_result_t r;
        longint p, y, up, n, mag, pos, sp, sg, term, g;
        p = longint'(el.logit);
        y = (el.target > 17'(OneQ)) ? OneQ : longint'(el.target);
        up = longint'($signed(upstream));
        n = (elem_count == 0) ? 1 : longint'(elem_count);
        mag = (p < 0) ? -p : p;
        pos = mag * Ents;
        sp = lut_read(1'b0, pos / (longint'(16) << 16), pos % (longint'(16) << 16));
        sg = lut_read(1'b1, pos / (longint'(16) << 16), pos % (longint'(16) << 16));
        if (p < 0)
            sg = OneQ - sg;
        term = ((p > 0) ? p : 0) - (p * y) / OneQ + sp;
        if (term < 0)
            term = 0;
        if (64'(term) > LossSumCap - loss_acc)
            loss_acc = LossSumCap;
        else
            loss_acc = loss_acc + 64'(term);
        g = longint'(el.grad_in) + (up * (sg - y)) / (OneQ * n);
        r.grad_sat = 1'b0;
        if (g > 64'sd2147483647)
        begin
            g = 64'sd2147483647;
            r.grad_sat = 1'b1;
        end
        else if (g < -64'sd2147483648)
        begin
            g = -64'sd2147483648;
            r.grad_sat = 1'b1;
        end
        r.grad_out = g[31:0];
        r.loss_valid = el.last;
        r.mean_loss = '0;
        if (el.last)
        begin
            r.mean_loss = 34'((loss_acc / 64'(n) > MeanCap) ? MeanCap : loss_acc / 64'(n));
            loss_acc = 0;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // source side
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !in_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_elems.size() > 0)
            begin
                element_t el;
                el = pending_elems.pop_front();
                s_axis_tdata <= {7'b0, el.grad_in, el.target, el.logit};
                s_axis_tlast <= el.last;
                s_axis_tvalid <= 1'b1;
                src_gap <= src_steady ? 0 : pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        in_taken <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            element_t el;
            el.logit = s_axis_tdata[31:0];
            el.target = s_axis_tdata[48:32];
            el.grad_in = s_axis_tdata[80:49];
            el.last = s_axis_tlast;
            expected_grads.push_back(bce_element(el));
            in_taken <= 1'b1;
        end
    end

    // sink side
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!sink_steady && $urandom_range(3) == 0)
                sink_gap <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_grads.size() == 0)
            begin
                $display("%0t: unexpected beat, actual %h user %b", $time, m_axis_tdata,
                    m_axis_tuser);
                errors++;
            end
            else
            begin
                grad_result_t ex;
                ex = expected_grads.pop_front();
                if (m_axis_tdata[31:0] !== ex.grad_out)
                begin
                    $display("%0t: grad_out expected %h actual %h", $time, ex.grad_out,
                        m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[32] !== ex.grad_sat)
                begin
                    $display("%0t: grad_saturated expected %b actual %b", $time, ex.grad_sat,
                        m_axis_tdata[32]);
                    errors++;
                end
                if (m_axis_tdata[66:33] !== ex.mean_loss)
                begin
                    $display("%0t: mean_loss expected %h actual %h", $time, ex.mean_loss,
                        m_axis_tdata[66:33]);
                    errors++;
                end
                if (m_axis_tuser !== ex.loss_valid)
                begin
                    $display("%0t: loss_valid expected %b actual %b", $time, ex.loss_valid,
                        m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic add_elem(input logic [31:0] p, input logic [16:0] y, input logic [31:0] g,
        input logic last);
        element_t el;
        el.logit = p;
        el.target = y;
        el.grad_in = g;
        el.last = last;
        pending_elems.push_back(el);
    endtask

    task automatic add_random_elem(input logic last);
        logic [31:0] p, g;
        logic [16:0] y;
        int r;
        r = $urandom_range(9);
        if (r < 5)
            p = 32'($signed($urandom_range(40 << 16)) - (20 << 16));
        else if (r < 7)
            p = 32'($signed($urandom_range(2 << 16)) - (1 << 16));
        else
            p = $urandom;
        r = $urandom_range(9);
        if (r < 8)
            y = 17'($urandom_range(65536));
        else if (r < 9)
            y = $urandom_range(1) ? 17'd65536 : 17'd0;
        else
            y = 17'($urandom);
        g = ($urandom_range(9) < 6) ? 32'($signed($urandom_range(1 << 21)) - (1 << 20))
                                    : $urandom;
        add_elem(p, y, g, last);
    endtask

    task automatic wait_drained();
        while (pending_elems.size() > 0 || s_axis_tvalid || expected_grads.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input bce_pkg::cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == bce_pkg::CfgElementCount)
            elem_count = val[23:0];
        else
            upstream = val;
    endtask

    initial
    begin
        logic [23:0] counts [6];
        logic [31:0] grads [6];
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = bce_pkg::CfgElementCount;
        cfg_wdata = '0;
        in_taken = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        src_steady = 1'b0;
        sink_steady = 1'b0;
        errors = 0;
        elem_count = 24'd1;
        upstream = 32'd65536;
        loss_acc = 0;
        fill_luts();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed elements at reset configuration
        add_elem(32'd0, 17'd0, 32'd0, 1'b0);
        add_elem(32'h7fffffff, 17'd65536, 32'd0, 1'b0);
        add_elem(32'h80000000, 17'd0, 32'd0, 1'b1);
        add_elem(32'd16 << 16, 17'd0, 32'd5, 1'b0);
        add_elem(-(32'd16 << 16), 17'd65536, 32'd0, 1'b0);
        add_elem(32'd17 << 16, 17'd32768, 32'd0, 1'b0);
        add_elem(32'd1, 17'd1, 32'hffffffff, 1'b0);
        add_elem(32'hffffffff, 17'd65535, 32'd1, 1'b1);
        add_elem(32'd3 << 15, 17'h1ffff, 32'd0, 1'b0);
        add_elem(-(32'd5 << 14), 17'd65537, 32'd0, 1'b0);
        // gradient clipping at both ends
        add_elem(32'd10 << 16, 17'd0, 32'h7fffffff, 1'b0);
        add_elem(-(32'd10 << 16), 17'd65536, 32'h80000000, 1'b0);
        add_elem(32'd0, 17'd65536, 32'h7fffffff, 1'b0);
        add_elem(32'd1234567, 17'd40000, 32'h80000000, 1'b1);
        // large loss sum, still below the mean's saturation limit
        repeat (6) add_elem(32'h7fffffff, 17'd0, 32'd0, 1'b0);
        add_elem(32'h80000000, 17'd65536, 32'd0, 1'b1);
        wait_drained();

        counts = '{24'd3, 24'hffffff, 24'd0, 24'd1, 24'd0, 24'd100000};
        grads = '{32'd65536, 32'h80000000, 32'h7fffffff, 32'hffff0000, 32'd0, 32'd0};
        counts[4] = 24'($urandom_range(64, 1));
        grads[4] = $urandom;
        grads[5] = $urandom;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(bce_pkg::CfgElementCount, {8'b0, counts[ph]});
            write_reg(bce_pkg::CfgUpstreamGrad, grads[ph]);
            src_steady = (ph == 2);
            sink_steady = (ph == 3);
            for (int i = 0; i < 313; i++)
                add_random_elem((i == 312) || ($urandom_range(9) == 0));
            wait_drained();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bce_pkg.sv
rtl/bce_fifo.sv
rtl/bce_front.sv
rtl/bce_div.sv
rtl/bce_back.sv
rtl/bce_with_logits_loss_grad_core.sv
verif/tb_bce_with_logits_loss_grad_core.sv
